// ===== rtl/core/i2f_pkg.sv =====
// Shared constants and stage payload types for the integer to single-float converter.
package i2f_pkg;

  localparam int IntW  = 32;
  localparam int LzcW  = $clog2(IntW);
  localparam int FracW = 23;
  localparam int ExpW  = 8;
  localparam int SigW  = FracW + 1;
  localparam int ExpBias = 127;

  // Biased exponent of a value whose leading one sits at the top bit.
  localparam logic [ExpW-1:0] ExpTop = ExpW'(ExpBias + IntW - 1);

  // Payload after sign split and magnitude.
  typedef struct packed {
    logic            sign;
    logic [IntW-1:0] mag;
  } i2f_mag_t;

  // Payload after leading-one detection.
  typedef struct packed {
    logic            sign;
    logic            zero;
    logic [LzcW-1:0] lzc;
    logic [IntW-1:0] mag;
  } i2f_lzc_t;

  // Payload after normalization, leading one at the top bit.
  typedef struct packed {
    logic            sign;
    logic            zero;
    logic [LzcW-1:0] lzc;
    logic [IntW-1:0] norm;
  } i2f_norm_t;

endpackage

// ===== rtl/core/i2f_if.sv =====
// Valid/ready channel interfaces for the integer input and the float result.
interface i2f_in_if;
  logic                          valid;
  logic                          ready;
  logic signed [i2f_pkg::IntW-1:0] int_value;

  modport source (output valid, output int_value, input ready);
  modport sink (input valid, input int_value, output ready);
endinterface

interface i2f_out_if;
  logic                    valid;
  logic                    ready;
  logic [i2f_pkg::IntW-1:0] float_bits;

  modport source (output valid, output float_bits, input ready);
  modport sink (input valid, input float_bits, output ready);
endinterface

// ===== rtl/core/int32_to_float32_convert.sv =====
// Signed 32-bit integer to IEEE-754 single converter, four register stages.
// Throughput: one transaction per cycle while out_ch is not stalled; the stages
// are magnitude, leading-zero count, normalizing shift and round/pack, each
// with its own valid bit.
// A stage holds its content while the one after it is full and stalled.
// Reset (synchronous, active low) clears all stage valid bits; data is not reset.
module int32_to_float32_convert (
  input logic      clk,
  input logic      rst_n,
  i2f_in_if.sink   in_ch,
  i2f_out_if.source out_ch
);

  logic               abs_valid;
  logic               abs_ready;
  i2f_pkg::i2f_mag_t  abs_data;
  logic               lzc_valid;
  logic               lzc_ready;
  i2f_pkg::i2f_lzc_t  lzc_data;
  logic               norm_valid;
  logic               norm_ready;
  i2f_pkg::i2f_norm_t norm_data;

  // Sign split and magnitude.
  i2f_abs u_abs (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_ch.valid),
    .up_ready (in_ch.ready),
    .up_value (in_ch.int_value),
    .dn_valid (abs_valid),
    .dn_ready (abs_ready),
    .dn_data  (abs_data)
  );

  // Leading-zero count.
  i2f_lzc u_lzc (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (abs_valid),
    .up_ready (abs_ready),
    .up_data  (abs_data),
    .dn_valid (lzc_valid),
    .dn_ready (lzc_ready),
    .dn_data  (lzc_data)
  );

  // Normalizing shift.
  i2f_norm u_norm (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (lzc_valid),
    .up_ready (lzc_ready),
    .up_data  (lzc_data),
    .dn_valid (norm_valid),
    .dn_ready (norm_ready),
    .dn_data  (norm_data)
  );

  // Rounding and packing into the output register.
  i2f_round u_round (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (norm_valid),
    .up_ready (norm_ready),
    .up_data  (norm_data),
    .dn_valid (out_ch.valid),
    .dn_ready (out_ch.ready),
    .dn_bits  (out_ch.float_bits)
  );

endmodule

// ===== rtl/core/i2f_abs.sv =====
// First stage: splits off the sign and registers the magnitude.
module i2f_abs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           up_valid,
  output logic                           up_ready,
  input  logic signed [i2f_pkg::IntW-1:0] up_value,
  output logic                           dn_valid,
  input  logic                           dn_ready,
  output i2f_pkg::i2f_mag_t              dn_data
);

  logic              valid_r;
  i2f_pkg::i2f_mag_t data_r;
  i2f_pkg::i2f_mag_t data_nxt;
  logic [i2f_pkg::IntW-1:0] raw;

  // The stage takes a new transaction when empty or when its content moves on.
  assign up_ready = !valid_r || dn_ready;

  // Two's complement negation; the most negative value maps onto itself, which is exact.
  always_comb begin
    raw           = up_value;
    data_nxt.sign = raw[i2f_pkg::IntW-1];
    data_nxt.mag  = raw[i2f_pkg::IntW-1] ? (~raw + 1'b1) : raw;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

// ===== rtl/core/i2f_lzc.sv =====
// Second stage: counts leading zeros of the magnitude and flags a zero value.
module i2f_lzc (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              up_valid,
  output logic              up_ready,
  input  i2f_pkg::i2f_mag_t up_data,
  output logic              dn_valid,
  input  logic              dn_ready,
  output i2f_pkg::i2f_lzc_t dn_data
);

  logic              valid_r;
  i2f_pkg::i2f_lzc_t data_r;
  i2f_pkg::i2f_lzc_t data_nxt;

  assign up_ready = !valid_r || dn_ready;

  // Priority encoder: the highest set bit wins since it is visited last.
  always_comb begin
    data_nxt.sign = up_data.sign;
    data_nxt.mag  = up_data.mag;
    data_nxt.zero = (up_data.mag == '0);
    data_nxt.lzc  = '0;
    for (int i = 0; i < i2f_pkg::IntW; i++) begin
      if (up_data.mag[i]) begin
        data_nxt.lzc = i2f_pkg::LzcW'(i2f_pkg::IntW - 1 - i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

// ===== rtl/core/i2f_norm.sv =====
// Third stage: shifts the magnitude left so that its leading one sits at the top bit.
module i2f_norm (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               up_valid,
  output logic               up_ready,
  input  i2f_pkg::i2f_lzc_t  up_data,
  output logic               dn_valid,
  input  logic               dn_ready,
  output i2f_pkg::i2f_norm_t dn_data
);

  logic               valid_r;
  i2f_pkg::i2f_norm_t data_r;
  i2f_pkg::i2f_norm_t data_nxt;

  assign up_ready = !valid_r || dn_ready;

  // Barrel shift by the leading-zero count.
  always_comb begin
    data_nxt.sign = up_data.sign;
    data_nxt.zero = up_data.zero;
    data_nxt.lzc  = up_data.lzc;
    data_nxt.norm = up_data.mag << up_data.lzc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

// ===== rtl/core/i2f_round.sv =====
// Fourth stage: rounds to nearest even, packs sign, exponent and fraction into the output register.
module i2f_round (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     up_valid,
  output logic                     up_ready,
  input  i2f_pkg::i2f_norm_t       up_data,
  output logic                     dn_valid,
  input  logic                     dn_ready,
  output logic [i2f_pkg::IntW-1:0] dn_bits
);

  localparam int DropW = i2f_pkg::IntW - i2f_pkg::SigW;

  logic                      valid_r;
  logic [i2f_pkg::IntW-1:0]  bits_r;
  logic [i2f_pkg::IntW-1:0]  bits_nxt;
  logic [i2f_pkg::SigW-1:0]  sig;
  logic                      guard;
  logic                      sticky;
  logic                      round_up;
  logic [i2f_pkg::SigW:0]    sig_rnd;
  logic [i2f_pkg::ExpW-1:0]  expo;
  logic [i2f_pkg::FracW-1:0] frac;

  assign up_ready = !valid_r || dn_ready;

  // Round to nearest, ties to even, on the bits below the 24-bit significand.
  always_comb begin
    sig      = up_data.norm[i2f_pkg::IntW-1 -: i2f_pkg::SigW];
    guard    = up_data.norm[DropW-1];
    sticky   = |up_data.norm[DropW-2:0];
    round_up = guard && (sticky || sig[0]);
    sig_rnd  = {1'b0, sig} + {{i2f_pkg::SigW{1'b0}}, round_up};
    // A carry out of the significand leaves an all-zero fraction and bumps the exponent.
    expo     = i2f_pkg::ExpTop - i2f_pkg::ExpW'(up_data.lzc)
               + i2f_pkg::ExpW'(sig_rnd[i2f_pkg::SigW]);
    frac     = sig_rnd[i2f_pkg::SigW] ? '0 : sig_rnd[i2f_pkg::FracW-1:0];
    if (up_data.zero) begin
      bits_nxt = '0;
    end else begin
      bits_nxt = {up_data.sign, expo, frac};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      bits_r <= bits_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_bits  = bits_r;

endmodule
